>>> rtl/asgg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package asgg_pkg;

    // fixed field widths
    localparam int VTX_W   = 24;
    localparam int COORD_W = 32;
    localparam int COLS_W  = 7;
    localparam int ROWS_W  = 12;
    localparam int BASE_W  = 24;
    localparam int TDATA_W = 88;
    localparam int TUSER_W = 3;
    localparam int CFG_AW  = 5;

    // register indexes (byte address = 4 * index)
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_ORIGIN_U   = 3'd0;
    localparam t_reg_idx REG_TOP_V      = 3'd1;
    localparam t_reg_idx REG_STEP_U     = 3'd2;
    localparam t_reg_idx REG_STEP_V     = 3'd3;
    localparam t_reg_idx REG_COLS       = 3'd4;
    localparam t_reg_idx REG_ROWS       = 3'd5;
    localparam t_reg_idx REG_INDEX_BASE = 3'd6;

    // phase of an entry inside a cell, counted from the first cell entry
    typedef logic [1:0] t_phase;
    localparam t_phase PH_NEAR = 2'd0;   // reuses previous entry 4j+5
    localparam t_phase PH_MID  = 2'd1;   // reuses previous entry 4j+4
    localparam t_phase PH_FAR  = 2'd2;   // reuses previous entry 4j+6
    localparam t_phase PH_APEX = 2'd3;   // always a new vertex

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_u;
        logic signed [COORD_W-1:0] top_v;
        logic signed [COORD_W-1:0] step_u;
        logic signed [COORD_W-1:0] step_v;
        logic [COLS_W-1:0]         cols;
        logic [ROWS_W-1:0]         rows;
        logic [BASE_W-1:0]         index_base;
    } t_cfg;

    typedef struct packed {
        logic [VTX_W-1:0]          vertex_index;
        logic                      new_vertex;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
        logic                      strip_last;
        logic                      grid_last;
        logic                      idle;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/adjacency_strip_grid_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Adjacency strip grid generator. Each word taken on the slave stream is a
// request (bit 0 set restarts the grid at its first entry) and yields exactly
// one word on the master stream: the next entry of a grid of triangle-with-
// adjacency strips, cols by rows cells, 4*cols+4 entries per strip, or an idle
// word once the grid is done or empty. Program origin_u, top_v, step_u,
// step_v, cols, rows and index_base over the APB port while no request is in
// flight. One request is taken every clock cycle while the skid is empty; its
// entry is registered in the output stage, or in the skid on a stall. That
// rate is set by one pass through the walk counters, the coordinate adders and
// a line store read issued ahead from the next position. The line store needs
// no clearing pass: it is only read at entries written in an earlier strip.
module adjacency_strip_grid_generator
    import asgg_pkg::*;
#(
    parameter int MAX_COLS   = 64,
    parameter int INDEX_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request stream
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [0] restart
    // entry stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // vertex_index, coord_u, coord_v
    output logic                    m_axis_tlast,   // strip_last
    output logic [TUSER_W-1:0]      m_axis_tuser,   // new_vertex, grid_last, idle
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    t_cfg     r_cfg;
    t_result  core_result;
    t_result  out_result;
    logic     in_fire;
    logic     cfg_wr;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ORIGIN_U:   r_cfg.origin_u   <= pwdata;
                REG_TOP_V:      r_cfg.top_v      <= pwdata;
                REG_STEP_U:     r_cfg.step_u     <= pwdata;
                REG_STEP_V:     r_cfg.step_v     <= pwdata;
                REG_COLS:       r_cfg.cols       <= pwdata[COLS_W-1:0];
                REG_ROWS:       r_cfg.rows       <= pwdata[ROWS_W-1:0];
                REG_INDEX_BASE: r_cfg.index_base <= pwdata[BASE_W-1:0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_ORIGIN_U:   prdata = r_cfg.origin_u;
            REG_TOP_V:      prdata = r_cfg.top_v;
            REG_STEP_U:     prdata = r_cfg.step_u;
            REG_STEP_V:     prdata = r_cfg.step_v;
            REG_COLS:       prdata = 32'(r_cfg.cols);
            REG_ROWS:       prdata = 32'(r_cfg.rows);
            REG_INDEX_BASE: prdata = 32'(r_cfg.index_base);
            default:        prdata = '0;
        endcase
    end

    assign in_fire = s_axis_tvalid && s_axis_tready;

    asgg_core #(
        .MAX_COLS   (MAX_COLS),
        .INDEX_BITS (INDEX_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (in_fire),
        .i_restart (s_axis_tdata[0]),
        .i_cfg     (r_cfg),
        .o_result  (core_result)
    );

    asgg_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_fire),
        .i_result (core_result),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    // output word packing
    assign m_axis_tdata = {out_result.coord_v, out_result.coord_u, out_result.vertex_index};
    assign m_axis_tlast = out_result.strip_last;
    assign m_axis_tuser = {out_result.idle, out_result.grid_last, out_result.new_vertex};

endmodule

`default_nettype wire

>>> rtl/asgg_core.sv
`timescale 1ns / 1ps
`default_nettype none

module asgg_core
    import asgg_pkg::*;
#(
    parameter int MAX_COLS   = 64,
    parameter int INDEX_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire logic i_restart,
    input  wire t_cfg i_cfg,
    output t_result   o_result
);

    localparam int STRIP_LEN = 4 * MAX_COLS + 4;
    localparam int POS_W     = $clog2(STRIP_LEN);
    localparam logic [POS_W:0] STRIP_LEN_W = (POS_W + 1)'(STRIP_LEN);

    // walk state
    logic [ROWS_W-1:0]         r_row,      n_row;
    logic [POS_W-1:0]          r_pos,      n_pos;
    logic [INDEX_BITS-1:0]     r_next_idx, n_next_idx;
    logic [COORD_W-1:0]        r_u,        n_u;
    logic [COORD_W-1:0]        r_v,        n_v;
    logic                      r_finished, n_finished;

    // line store: holds the strip being built, over the previous one
    logic [INDEX_BITS-1:0]     r_line [STRIP_LEN];
    logic [INDEX_BITS-1:0]     r_rd_data;
    logic [POS_W-1:0]          rd_addr;
    logic [POS_W:0]            rd_sum;

    // state as seen by this word, after a restart request
    logic [ROWS_W-1:0]         e_row;
    logic [POS_W-1:0]          e_pos;
    logic [INDEX_BITS-1:0]     e_idx;
    logic [COORD_W-1:0]        e_u;
    logic [COORD_W-1:0]        e_v;
    logic                      e_fin;

    logic [COLS_W-1:0]         c;
    logic [POS_W-1:0]          last;
    logic                      grid_idle;
    t_phase                    ph;
    t_phase                    n_ph;

    logic [COORD_W-1:0]        u_minus, u_plus, v_down, v_up, v_down2;
    logic                      is_new, is_reuse, slast, glast, adv_u;
    logic [COORD_W-1:0]        cu, cv;
    logic [INDEX_BITS-1:0]     vi;

    // restart override
    always_comb begin
        if (i_restart) begin
            e_row = '0;
            e_pos = '0;
            e_idx = INDEX_BITS'(i_cfg.index_base);
            e_u   = i_cfg.origin_u;
            e_v   = i_cfg.top_v;
            e_fin = 1'b0;
        end else begin
            e_row = r_row;
            e_pos = r_pos;
            e_idx = r_next_idx;
            e_u   = r_u;
            e_v   = r_v;
            e_fin = r_finished;
        end
    end

    // column clamp, strip length and grid end test
    assign c         = (32'(i_cfg.cols) > 32'(MAX_COLS)) ? COLS_W'(MAX_COLS) : i_cfg.cols;
    assign last      = POS_W'({c, 2'b11});
    assign grid_idle = e_fin || (c == '0) || (e_row >= i_cfg.rows);
    assign ph        = e_pos[1:0] ^ 2'b10;

    // coordinate candidates (v_down and v_down2 apply the negated row step)
    assign u_minus = e_u - i_cfg.step_u;
    assign u_plus  = e_u + i_cfg.step_u;
    assign v_down  = e_v - i_cfg.step_v;
    assign v_up    = e_v + i_cfg.step_v;
    assign v_down2 = e_v - {i_cfg.step_v[COORD_W-2:0], 1'b0};

    // entry decode
    always_comb begin
        is_new   = 1'b0;
        is_reuse = 1'b0;
        slast    = 1'b0;
        adv_u    = 1'b0;
        cu       = '0;
        cv       = '0;
        if (grid_idle) begin
            is_new = 1'b0;
        end else if (e_pos == '0) begin
            if (e_row == '0) begin
                is_new = 1'b1;
                cu     = e_u;
                cv     = e_v;
            end else begin
                is_reuse = 1'b1;
            end
        end else if (e_pos == POS_W'(1)) begin
            is_new = 1'b1;
            cu     = u_minus;
            cv     = v_down;
        end else if (e_pos < last - POS_W'(1)) begin
            adv_u = (ph == PH_APEX);
            if (e_row == '0) begin
                is_new = 1'b1;
                case (ph)
                    PH_NEAR: begin cu = e_u;    cv = v_down;  end
                    PH_MID:  begin cu = u_plus; cv = v_up;    end
                    PH_FAR:  begin cu = u_plus; cv = e_v;     end
                    default: begin cu = e_u;    cv = v_down2; end
                endcase
            end else if (ph == PH_APEX) begin
                is_new = 1'b1;
                cu     = e_u;
                cv     = v_down2;
            end else begin
                is_reuse = 1'b1;
            end
        end else if (e_pos == last - POS_W'(1)) begin
            is_new = 1'b1;
            cu     = e_u;
            cv     = v_down;
        end else begin
            is_new = 1'b1;
            cu     = u_plus;
            cv     = e_v;
            slast  = 1'b1;
        end
    end

    assign vi    = is_new ? e_idx : r_rd_data;
    assign glast = slast && ({1'b0, e_row} + (ROWS_W + 1)'(1) >= {1'b0, i_cfg.rows});

    // result word
    always_comb begin
        o_result              = '0;
        o_result.idle         = grid_idle;
        o_result.vertex_index = (is_new || is_reuse) ? VTX_W'(vi) : '0;
        o_result.new_vertex   = is_new;
        o_result.coord_u      = cu;
        o_result.coord_v      = cv;
        o_result.strip_last   = slast;
        o_result.grid_last    = glast;
    end

    // next walk state
    always_comb begin
        n_row      = r_row;
        n_pos      = r_pos;
        n_next_idx = r_next_idx;
        n_u        = r_u;
        n_v        = r_v;
        n_finished = r_finished;
        if (i_fire) begin
            n_row      = e_row;
            n_pos      = e_pos;
            n_next_idx = e_idx;
            n_u        = e_u;
            n_v        = e_v;
            n_finished = e_fin;
            if (grid_idle) begin
                n_finished = 1'b1;
            end else begin
                if (is_new) begin
                    n_next_idx = e_idx + INDEX_BITS'(1);
                end
                if (adv_u) begin
                    n_u = u_plus;
                end
                if (slast) begin
                    n_pos = '0;
                    n_u   = i_cfg.origin_u;
                    n_v   = v_down;
                    n_row = e_row + ROWS_W'(1);
                    if (glast) begin
                        n_finished = 1'b1;
                    end
                end else begin
                    n_pos = e_pos + POS_W'(1);
                end
            end
        end
    end

    // read address for the entry at the next position
    assign n_ph = n_pos[1:0] ^ 2'b10;
    always_comb begin
        rd_sum = '0;
        if (n_pos == '0) begin
            rd_sum = (POS_W + 1)'(2);
        end else if (n_pos != POS_W'(1)) begin
            case (n_ph)
                PH_NEAR: rd_sum = {1'b0, n_pos} + (POS_W + 1)'(3);
                PH_MID:  rd_sum = {1'b0, n_pos} + (POS_W + 1)'(1);
                PH_FAR:  rd_sum = {1'b0, n_pos} + (POS_W + 1)'(2);
                default: rd_sum = '0;
            endcase
        end
        rd_addr = (rd_sum < STRIP_LEN_W) ? POS_W'(rd_sum) : '0;
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_pos      <= '0;
            r_next_idx <= '0;
            r_u        <= '0;
            r_v        <= '0;
            r_finished <= 1'b1;
        end else begin
            r_row      <= n_row;
            r_pos      <= n_pos;
            r_next_idx <= n_next_idx;
            r_u        <= n_u;
            r_v        <= n_v;
            r_finished <= n_finished;
        end
    end

    // line store write at the current position, read ahead for the next one
    always_ff @(posedge i_clk) begin
        if (i_fire && !grid_idle) begin
            r_line[e_pos] <= vi;
        end
        r_rd_data <= r_line[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/asgg_out_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module asgg_out_skid
    import asgg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_out_valid,  n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_take;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign out_take = !r_out_valid || i_ready;

    // occupancy of output and skid stages
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_take) begin
            n_out_valid  = r_skid_valid || i_load;
            n_skid_valid = 1'b0;
        end else if (i_load) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // word payloads
    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_load) begin
            r_skid <= i_result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/asgg_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module asgg_checker
    import asgg_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic               m_axis_tlast,
    input wire logic [TUSER_W-1:0] m_axis_tuser
);

    // an idle word carries nothing else
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tdata == '0 && !m_axis_tlast && m_axis_tuser[1:0] == 2'b00)
        else $error("idle word with payload");

    // the grid ends only on the end of a strip, on a new vertex
    a_grid_on_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && m_axis_tuser[0])
        else $error("grid end outside strip end");

    // reused entries carry no coordinates
    a_reuse_no_coord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[TDATA_W-1:VTX_W] == '0)
        else $error("coordinates on a reused entry");

    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled word changed");

endmodule

bind adjacency_strip_grid_generator asgg_checker u_checker (.*);

`default_nettype wire
